// ===== design/ffv_va_pkg.sv =====
// Shared types and constants for the FFV vertex amplitude pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package ffv_va_pkg;

   localparam int PART_W    = 32;            // one signed Q8.24 part
   localparam int WORD_W    = 64;            // packed complex word
   localparam int Q_FRAC    = 24;            // fraction bits
   localparam int HALF_LSB  = 1 << (Q_FRAC - 1);
   localparam int N_LANE    = 4;             // spinor / polarization components
   localparam int CMUL_GROW = 9;             // growth of a rounded complex product

   // exact widths of the intermediate values
   localparam int ESUM_W = PART_W + 1;                // e0+e3 etc.
   localparam int BRK_W  = ESUM_W + CMUL_GROW + 1;    // bracket sums
   localparam int U_W    = BRK_W + CMUL_GROW;         // fi * bracket
   localparam int TERM_W = U_W + CMUL_GROW;           // coupling * (fi * bracket)
   localparam int ACC_W  = 64;                        // sum of the four terms

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_COUPLING_LEFT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUPLING_RIGHT = 2'd1;

   // polarization combination selects
   localparam int ESUM_E0P3  = 0;   // e0 + e3
   localparam int ESUM_E0M3  = 1;   // e0 - e3
   localparam int ESUM_E1PI2 = 2;   // e1 + i*e2
   localparam int ESUM_E1MI2 = 3;   // e1 - i*e2

   typedef struct packed {
      logic signed [PART_W-1:0] re;
      logic signed [PART_W-1:0] im;
   } cpx_type;

   typedef struct packed {
      logic signed [ESUM_W-1:0] re;
      logic signed [ESUM_W-1:0] im;
   } esum_type;

   typedef struct packed {
      logic signed [BRK_W-1:0] re;
      logic signed [BRK_W-1:0] im;
   } brk_type;

endpackage

`default_nettype wire

// ===== design/ffv_va_cmul.sv =====
// Two-stage complex multiplier with round-half-up to Q24.
// The wide operand is split at bit 24 into two partial products. Uses ffv_va_pkg.
`default_nettype none

module ffv_va_cmul
   import ffv_va_pkg::*;
#(
   parameter int BW = 33
) (
   input  wire logic                          clock,
   input  wire logic signed [PART_W-1:0]      a_re,
   input  wire logic signed [PART_W-1:0]      a_im,
   input  wire logic signed [BW-1:0]          b_re,
   input  wire logic signed [BW-1:0]          b_im,
   output logic signed [BW+CMUL_GROW-1:0]     p_re,
   output logic signed [BW+CMUL_GROW-1:0]     p_im
);

   localparam int HW  = BW - Q_FRAC;          // upper slice of b
   localparam int LW  = PART_W + Q_FRAC + 1;  // a * lower slice
   localparam int HPW = PART_W + HW;          // a * upper slice
   localparam int RW  = BW + CMUL_GROW;

   // real products: 0 ar*br, 1 ai*bi, 2 ar*bi, 3 ai*br
   logic signed [PART_W-1:0] mul_a [4];
   logic signed [BW-1:0]     mul_b [4];
   logic signed [LW-1:0]     lo_ff [4];
   logic signed [HPW-1:0]    hi_ff [4];
   logic signed [LW-1:0]     lo_rnd [4];
   logic signed [RW-1:0]     prod [4];
   logic signed [RW-1:0]     p_re_ff;
   logic signed [RW-1:0]     p_im_ff;

   always_comb begin
      mul_a[0] = a_re;  mul_b[0] = b_re;
      mul_a[1] = a_im;  mul_b[1] = b_im;
      mul_a[2] = a_re;  mul_b[2] = b_im;
      mul_a[3] = a_im;  mul_b[3] = b_re;
   end

   // stage 1: partial products
   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         lo_ff[k] <= mul_a[k] * $signed({1'b0, mul_b[k][Q_FRAC-1:0]});
         hi_ff[k] <= mul_a[k] * $signed(mul_b[k][BW-1:Q_FRAC]);
      end
   end

   // stage 2: a*hi + floor((a*lo + half) / 2^24), then complex combine
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         lo_rnd[k] = (lo_ff[k] + LW'(HALF_LSB)) >>> Q_FRAC;
         prod[k]   = RW'(hi_ff[k]) + RW'(lo_rnd[k]);
      end
   end

   always_ff @(posedge clock) begin
      p_re_ff <= prod[0] - prod[1];
      p_im_ff <= prod[2] + prod[3];
   end

   assign p_re = p_re_ff;
   assign p_im = p_im_ff;

endmodule

`default_nettype wire

// ===== design/ffv_va_bracket.sv =====
// Bracket stage: eight spinor-times-polarization complex products and their sums.
// Uses ffv_va_pkg and ffv_va_cmul; three register stages.
`default_nettype none

module ffv_va_bracket
   import ffv_va_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   input  wire cpx_type  fo [N_LANE],
   input  wire esum_type es [N_LANE],
   output logic          out_valid,
   output brk_type       t [N_LANE]
);

   localparam int PW = ESUM_W + CMUL_GROW;

   // product g feeds bracket g/2; odd products are added (t0,t1) or subtracted (t2,t3)
   localparam int FO_SEL [8] = '{2, 3, 2, 3, 0, 1, 1, 0};
   localparam int E_SEL  [8] = '{ESUM_E0P3, ESUM_E1PI2, ESUM_E1MI2, ESUM_E0M3,
                                 ESUM_E0M3, ESUM_E1PI2, ESUM_E0P3, ESUM_E1MI2};

   logic signed [PW-1:0] p_re [8];
   logic signed [PW-1:0] p_im [8];
   brk_type              t_ff [N_LANE];
   logic [2:0]           vld_ff;

   for (genvar g = 0; g < 8; g++) begin : g_prod
      ffv_va_cmul #(.BW(ESUM_W)) u_cmul (
         .clock (clock),
         .a_re  (fo[FO_SEL[g]].re),
         .a_im  (fo[FO_SEL[g]].im),
         .b_re  (es[E_SEL[g]].re),
         .b_im  (es[E_SEL[g]].im),
         .p_re  (p_re[g]),
         .p_im  (p_im[g])
      );
   end

   for (genvar j = 0; j < N_LANE; j++) begin : g_sum
      if (j < 2) begin : g_add
         always_ff @(posedge clock) begin
            t_ff[j].re <= BRK_W'(p_re[2*j]) + BRK_W'(p_re[2*j+1]);
            t_ff[j].im <= BRK_W'(p_im[2*j]) + BRK_W'(p_im[2*j+1]);
         end
      end else begin : g_sub
         always_ff @(posedge clock) begin
            t_ff[j].re <= BRK_W'(p_re[2*j]) - BRK_W'(p_re[2*j+1]);
            t_ff[j].im <= BRK_W'(p_im[2*j]) - BRK_W'(p_im[2*j+1]);
         end
      end
      assign t[j] = t_ff[j];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   assign out_valid = vld_ff[2];

endmodule

`default_nettype wire

// ===== design/ffv_va_sum_sat.sv =====
// Final stage: adds the four coupling terms and clamps each part to Q8.24.
// Uses ffv_va_pkg; two register stages.
`default_nettype none

module ffv_va_sum_sat
   import ffv_va_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire logic signed [TERM_W-1:0] term_re [N_LANE],
   input  wire logic signed [TERM_W-1:0] term_im [N_LANE],
   output logic                          out_valid,
   output logic [WORD_W-1:0]             value,
   output logic                          saturated
);

   logic signed [ACC_W-1:0] acc_re_in, acc_im_in;
   logic signed [ACC_W-1:0] acc_re_ff, acc_im_ff;
   logic                    ovf_re, ovf_im;
   logic [PART_W-1:0]       res_re, res_im;
   logic [WORD_W-1:0]       value_ff;
   logic                    sat_ff;
   logic [1:0]              vld_ff;

   always_comb begin
      acc_re_in = '0;
      acc_im_in = '0;
      for (int k = 0; k < N_LANE; k++) begin
         acc_re_in = acc_re_in + ACC_W'(term_re[k]);
         acc_im_in = acc_im_in + ACC_W'(term_im[k]);
      end
   end

   always_ff @(posedge clock) begin
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
   end

   // in range iff the bits above the part's sign bit all copy it
   always_comb begin
      ovf_re = !((&acc_re_ff[ACC_W-1:PART_W-1]) || !(|acc_re_ff[ACC_W-1:PART_W-1]));
      ovf_im = !((&acc_im_ff[ACC_W-1:PART_W-1]) || !(|acc_im_ff[ACC_W-1:PART_W-1]));
      if (ovf_re) begin
         res_re = {acc_re_ff[ACC_W-1], {(PART_W-1){~acc_re_ff[ACC_W-1]}}};
      end else begin
         res_re = acc_re_ff[PART_W-1:0];
      end
      if (ovf_im) begin
         res_im = {acc_im_ff[ACC_W-1], {(PART_W-1){~acc_im_ff[ACC_W-1]}}};
      end else begin
         res_im = acc_im_ff[PART_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= {res_re, res_im};
      sat_ff   <= ovf_re | ovf_im;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[0], in_valid};
      end
   end

   assign out_valid = vld_ff[1];
   assign value     = value_ff;
   assign saturated = sat_ff;

endmodule

`default_nettype wire

// ===== design/ffv_vertex_amplitude_top.sv =====
// FFV vertex amplitude with chiral couplings, fully pipelined over packed Q8.24 words.
// Throughput: one transaction per cycle; busy stays low, nothing ever stalls.
// Reset (synchronous, active high) clears the valid pipeline and both couplings.
// Depends on ffv_va_pkg, ffv_va_bracket, ffv_va_cmul, ffv_va_sum_sat.
`default_nettype none

module ffv_vertex_amplitude_top
   import ffv_va_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request transaction
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [WORD_W-1:0]    req_out_spinor_0,
   input  wire logic [WORD_W-1:0]    req_out_spinor_1,
   input  wire logic [WORD_W-1:0]    req_out_spinor_2,
   input  wire logic [WORD_W-1:0]    req_out_spinor_3,
   input  wire logic [WORD_W-1:0]    req_in_spinor_0,
   input  wire logic [WORD_W-1:0]    req_in_spinor_1,
   input  wire logic [WORD_W-1:0]    req_in_spinor_2,
   input  wire logic [WORD_W-1:0]    req_in_spinor_3,
   input  wire logic [WORD_W-1:0]    req_polarization_0,
   input  wire logic [WORD_W-1:0]    req_polarization_1,
   input  wire logic [WORD_W-1:0]    req_polarization_2,
   input  wire logic [WORD_W-1:0]    req_polarization_3,
   // result transaction
   output logic                      rsp_valid,
   output logic [WORD_W-1:0]         rsp_amplitude_value,
   output logic                      rsp_saturated,
   // register writes
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_data
);

   // Pipeline map, in order from the accepting edge:
   //   input    : capture fo/fi, form e0+-e3 and e1+-i*e2 exactly
   //   bracket  : fo*e products, bracket sums t0..t3           (ffv_va_bracket)
   //   fi mul   : fi[j]*t[j]                                   (ffv_va_cmul x4)
   //   coupling : coupling*(fi*t); L for t0,t1, R for t2,t3   (ffv_va_cmul x4)
   //   sum      : four-term sum, then clamp                    (ffv_va_sum_sat)
   localparam int FI_DLY = 4;   // fi waits out the bracket stages

   logic [WORD_W-1:0] coupling_left_ff;
   logic [WORD_W-1:0] coupling_right_ff;

   logic      accept;
   logic      vld_s0_ff;
   cpx_type   fo_in [N_LANE];
   cpx_type   fi_in [N_LANE];
   cpx_type   ep_in [N_LANE];
   cpx_type   fo_s0_ff [N_LANE];
   esum_type  es_s0_ff [N_LANE];
   cpx_type   fi_dly_ff [FI_DLY][N_LANE];

   logic      brk_valid;
   brk_type   brk [N_LANE];

   logic [3:0] vld_mul_ff;   // fi*t and coupling multiplier stages

   logic signed [U_W-1:0]    u_re [N_LANE];
   logic signed [U_W-1:0]    u_im [N_LANE];
   logic signed [TERM_W-1:0] term_re [N_LANE];
   logic signed [TERM_W-1:0] term_im [N_LANE];
   cpx_type                  cpl [N_LANE];

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coupling_left_ff  <= '0;
         coupling_right_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COUPLING_LEFT:  coupling_left_ff  <= csr_data;
            CSR_COUPLING_RIGHT: coupling_right_ff <= csr_data;
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   // ---------------- input stage ----------------
   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      fo_in[0] = cpx_type'(req_out_spinor_0);
      fo_in[1] = cpx_type'(req_out_spinor_1);
      fo_in[2] = cpx_type'(req_out_spinor_2);
      fo_in[3] = cpx_type'(req_out_spinor_3);
      fi_in[0] = cpx_type'(req_in_spinor_0);
      fi_in[1] = cpx_type'(req_in_spinor_1);
      fi_in[2] = cpx_type'(req_in_spinor_2);
      fi_in[3] = cpx_type'(req_in_spinor_3);
      ep_in[0] = cpx_type'(req_polarization_0);
      ep_in[1] = cpx_type'(req_polarization_1);
      ep_in[2] = cpx_type'(req_polarization_2);
      ep_in[3] = cpx_type'(req_polarization_3);
   end

   always_ff @(posedge clock) begin
      fo_s0_ff <= fo_in;
      es_s0_ff[ESUM_E0P3].re  <= ESUM_W'(ep_in[0].re) + ESUM_W'(ep_in[3].re);
      es_s0_ff[ESUM_E0P3].im  <= ESUM_W'(ep_in[0].im) + ESUM_W'(ep_in[3].im);
      es_s0_ff[ESUM_E0M3].re  <= ESUM_W'(ep_in[0].re) - ESUM_W'(ep_in[3].re);
      es_s0_ff[ESUM_E0M3].im  <= ESUM_W'(ep_in[0].im) - ESUM_W'(ep_in[3].im);
      es_s0_ff[ESUM_E1PI2].re <= ESUM_W'(ep_in[1].re) - ESUM_W'(ep_in[2].im);
      es_s0_ff[ESUM_E1PI2].im <= ESUM_W'(ep_in[1].im) + ESUM_W'(ep_in[2].re);
      es_s0_ff[ESUM_E1MI2].re <= ESUM_W'(ep_in[1].re) + ESUM_W'(ep_in[2].im);
      es_s0_ff[ESUM_E1MI2].im <= ESUM_W'(ep_in[1].im) - ESUM_W'(ep_in[2].re);
      // fi rides alongside the bracket stages
      fi_dly_ff[0] <= fi_in;
      for (int s = 1; s < FI_DLY; s++) begin
         fi_dly_ff[s] <= fi_dly_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_s0_ff  <= 1'b0;
         vld_mul_ff <= '0;
      end else begin
         vld_s0_ff  <= accept;
         vld_mul_ff <= {vld_mul_ff[2:0], brk_valid};
      end
   end

   // ---------------- brackets ----------------
   ffv_va_bracket u_bracket (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_s0_ff),
      .fo        (fo_s0_ff),
      .es        (es_s0_ff),
      .out_valid (brk_valid),
      .t         (brk)
   );

   // ---------------- fi * bracket, then coupling ----------------
   assign cpl[0] = cpx_type'(coupling_left_ff);
   assign cpl[1] = cpx_type'(coupling_left_ff);
   assign cpl[2] = cpx_type'(coupling_right_ff);
   assign cpl[3] = cpx_type'(coupling_right_ff);

   for (genvar j = 0; j < N_LANE; j++) begin : g_lane
      ffv_va_cmul #(.BW(BRK_W)) u_fi_mul (
         .clock (clock),
         .a_re  (fi_dly_ff[FI_DLY-1][j].re),
         .a_im  (fi_dly_ff[FI_DLY-1][j].im),
         .b_re  (brk[j].re),
         .b_im  (brk[j].im),
         .p_re  (u_re[j]),
         .p_im  (u_im[j])
      );

      // user keeps couplings static while transactions are in flight; not enforced
      ffv_va_cmul #(.BW(U_W)) u_cpl_mul (
         .clock (clock),
         .a_re  (cpl[j].re),
         .a_im  (cpl[j].im),
         .b_re  (u_re[j]),
         .b_im  (u_im[j]),
         .p_re  (term_re[j]),
         .p_im  (term_im[j])
      );
   end

   // ---------------- sum and clamp ----------------
   ffv_va_sum_sat u_sum_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_mul_ff[3]),
      .term_re   (term_re),
      .term_im   (term_im),
      .out_valid (rsp_valid),
      .value     (rsp_amplitude_value),
      .saturated (rsp_saturated)
   );

endmodule

`default_nettype wire

// ===== design/ffv_va_checker.sv =====
// Port-level checks for ffv_vertex_amplitude_top, bound to every instance.
// Uses ffv_va_pkg for widths.
`default_nettype none

module ffv_va_checker
   import ffv_va_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 start,
   input wire logic                 busy,
   input wire logic                 rsp_valid,
   input wire logic [WORD_W-1:0]    rsp_amplitude_value,
   input wire logic                 rsp_saturated
);

   localparam int RSP_LAT = 10;
   localparam logic [PART_W-1:0] POS_LIM = {1'b0, {(PART_W-1){1'b1}}};
   localparam logic [PART_W-1:0] NEG_LIM = {1'b1, {(PART_W-1){1'b0}}};

   // every accepted transaction yields its result after the fixed latency
   a_rsp_follows_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##RSP_LAT rsp_valid)
      else $error("accepted transaction produced no result");

   // no result without a matching accepted transaction
   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, RSP_LAT))
      else $error("result without accepted transaction");

   // a clipped result carries a limit value in at least one part
   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_amplitude_value[WORD_W-1:PART_W] == POS_LIM ||
          rsp_amplitude_value[WORD_W-1:PART_W] == NEG_LIM ||
          rsp_amplitude_value[PART_W-1:0] == POS_LIM ||
          rsp_amplitude_value[PART_W-1:0] == NEG_LIM))
      else $error("saturated flag without a clamped part");

endmodule

bind ffv_vertex_amplitude_top ffv_va_checker u_va_checker (.*);

`default_nettype wire

// ===== verif/tb_ffv_vertex_amplitude_top.sv =====
// Self-checking testbench for ffv_vertex_amplitude_top: directed and random vertex
// transactions, coupling writes between phases, scoreboard with a fixed-point predictor.
// Depends on ffv_va_pkg and the ffv_vertex_amplitude_top RTL.

module tb_ffv_vertex_amplitude_top
   import ffv_va_pkg::*;
();

   // wide signed scalar; every intermediate of the amplitude fits with room to spare
   typedef logic signed [127:0] wide_type;
   typedef struct {
      wide_type re;
      wide_type im;
   } wcpx_type;

   // one request transaction: outgoing spinor, incoming spinor, polarization
   typedef struct packed {
      logic [N_LANE-1:0][WORD_W-1:0] fo;
      logic [N_LANE-1:0][WORD_W-1:0] fi;
      logic [N_LANE-1:0][WORD_W-1:0] eps;
   } vertex_type;

   typedef struct {
      logic [WORD_W-1:0] amp;
      logic              sat;
   } amplitude_type;

   // value styles for random words
   typedef enum int { VAL_UNIT, VAL_WIDE, VAL_FULL, VAL_EDGE } val_style_type;

   // register indexes past the last coupling: writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   // packed complex Q8.24 constants (real high, imaginary low)
   localparam logic [WORD_W-1:0] W_ZERO = 64'h0000_0000_0000_0000;
   localparam logic [WORD_W-1:0] W_ONE  = 64'h0100_0000_0000_0000;  // 1.0
   localparam logic [WORD_W-1:0] W_TWO  = 64'h0200_0000_0000_0000;  // 2.0
   localparam logic [WORD_W-1:0] W_I    = 64'h0000_0000_0100_0000;  // i
   localparam logic [WORD_W-1:0] W_HALF = 64'h0080_0000_0000_0000;  // 0.5
   localparam logic [WORD_W-1:0] W_LSB  = 64'h0000_0001_0000_0000;  // +1 ulp
   localparam logic [WORD_W-1:0] W_NLSB = 64'hFFFF_FFFF_0000_0000;  // -1 ulp
   localparam logic [WORD_W-1:0] W_MAX  = 64'h7FFF_FFFF_7FFF_FFFF;
   localparam logic [WORD_W-1:0] W_MIN  = 64'h8000_0000_8000_0000;
   localparam logic [WORD_W-1:0] W_MONE = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [WORD_W-1:0] W_RMAX = 64'h7FFF_FFFF_0000_0000;  // real part only
   localparam logic [WORD_W-1:0] W_RMIN = 64'h8000_0000_0000_0000;

   localparam wide_type PART_MAX = 128'sd2147483647;
   localparam wide_type PART_MIN = -128'sd2147483648;

   localparam int CYCLE_LIMIT  = 100000;  // well above the length of a run, even with every gap long
   localparam int FLUSH_CYCLES = 20;      // outlasts the pipeline latency
   localparam int N_PHASES     = 8;
   localparam int PHASE_ITEMS  = 50;

   // -------------------------------------------------------------------------
   // Scoreboard: holds its own copy of both couplings, predicts the amplitude
   // of every accepted transaction and checks results in order.
   // -------------------------------------------------------------------------
   class amplitude_scoreboard;
      logic [WORD_W-1:0] left_word;
      logic [WORD_W-1:0] right_word;
      amplitude_type     amplitudes_due[$];
      int unsigned       mismatches;

      function new();
         left_word  = '0;
         right_word = '0;
         mismatches = 0;
      endfunction

      function void write_coupling(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
         case (idx)
            CSR_COUPLING_LEFT:  left_word  = data;
            CSR_COUPLING_RIGHT: right_word = data;
            default: ;  // unmapped index, dropped
         endcase
      endfunction

      function wcpx_type unpack_word(logic [WORD_W-1:0] w);
         wcpx_type c;
         c.re = wide_type'($signed(w[WORD_W-1:PART_W]));
         c.im = wide_type'($signed(w[PART_W-1:0]));
         return c;
      endfunction

      // x*y on the Q24 scale, round half up (arithmetic shift is floor)
      function wide_type mul_round(wide_type a, wide_type b);
         wide_type p;
         p = a * b + wide_type'(HALF_LSB);
         return p >>> Q_FRAC;
      endfunction

      function wcpx_type cx_mul(wcpx_type a, wcpx_type b);
         wcpx_type r;
         r.re = mul_round(a.re, b.re) - mul_round(a.im, b.im);
         r.im = mul_round(a.re, b.im) + mul_round(a.im, b.re);
         return r;
      endfunction

      function wcpx_type cx_add(wcpx_type a, wcpx_type b);
         wcpx_type r;
         r.re = a.re + b.re;
         r.im = a.im + b.im;
         return r;
      endfunction

      function wcpx_type cx_sub(wcpx_type a, wcpx_type b);
         wcpx_type r;
         r.re = a.re - b.re;
         r.im = a.im - b.im;
         return r;
      endfunction

      function wide_type clamp_part(wide_type x, inout bit hit);
         if (x > PART_MAX) begin
            hit = 1'b1;
            return PART_MAX;
         end
         if (x < PART_MIN) begin
            hit = 1'b1;
            return PART_MIN;
         end
         return x;
      endfunction

      function void note_vertex(vertex_type v);
         wcpx_type      fo[N_LANE];
         wcpx_type      fi[N_LANE];
         wcpx_type      ep[N_LANE];
         wcpx_type      cl, cr, e0p3, e0m3, e1pi2, e1mi2, b0, b1, b2, b3, acc;
         wide_type      re, im;
         bit            hit;
         amplitude_type a;
         int            k;
         for (k = 0; k < N_LANE; k++) begin
            fo[k] = unpack_word(v.fo[k]);
            fi[k] = unpack_word(v.fi[k]);
            ep[k] = unpack_word(v.eps[k]);
         end
         cl = unpack_word(left_word);
         cr = unpack_word(right_word);
         // polarization combinations, exact
         e0p3     = cx_add(ep[0], ep[3]);
         e0m3     = cx_sub(ep[0], ep[3]);
         e1pi2.re = ep[1].re - ep[2].im;
         e1pi2.im = ep[1].im + ep[2].re;
         e1mi2.re = ep[1].re + ep[2].im;
         e1mi2.im = ep[1].im - ep[2].re;
         // one bracket per incoming spinor lane
         b2 = cx_sub(cx_mul(fo[0], e0m3), cx_mul(fo[1], e1pi2));
         b1 = cx_add(cx_mul(fo[2], e1mi2), cx_mul(fo[3], e0m3));
         b3 = cx_sub(cx_mul(fo[1], e0p3), cx_mul(fo[0], e1mi2));
         b0 = cx_add(cx_mul(fo[2], e0p3), cx_mul(fo[3], e1pi2));
         // lanes 2,3 take the right coupling, lanes 0,1 the left one
         acc = cx_mul(cr, cx_mul(fi[2], b2));
         acc = cx_add(acc, cx_mul(cl, cx_mul(fi[1], b1)));
         acc = cx_add(acc, cx_mul(cr, cx_mul(fi[3], b3)));
         acc = cx_add(acc, cx_mul(cl, cx_mul(fi[0], b0)));
         hit   = 1'b0;
         re    = clamp_part(acc.re, hit);
         im    = clamp_part(acc.im, hit);
         a.amp = {re[PART_W-1:0], im[PART_W-1:0]};
         a.sat = hit;
         amplitudes_due.push_back(a);
      endfunction

      function void check_amplitude(logic [WORD_W-1:0] amp, logic sat);
         amplitude_type want;
         if (amplitudes_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual amplitude %h sat %b",
                     $time, amp, sat);
            mismatches++;
         end else begin
            want = amplitudes_due.pop_front();
            if (amp !== want.amp) begin
               $display("%0t: amplitude mismatch, expected %h actual %h",
                        $time, want.amp, amp);
               mismatches++;
            end
            if (sat !== want.sat) begin
               $display("%0t: saturated mismatch, expected %b actual %b",
                        $time, want.sat, sat);
               mismatches++;
            end
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup; every input is known from time zero
   // -------------------------------------------------------------------------
   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              start     = 1'b0;
   logic              busy;
   vertex_type        req_v     = '0;
   logic              rsp_valid;
   logic [WORD_W-1:0] rsp_amplitude_value;
   logic              rsp_saturated;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0]    csr_data  = '0;
   int unsigned       cycle_count;

   amplitude_scoreboard amp_board = new();

   ffv_vertex_amplitude_top uut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_out_spinor_0    (req_v.fo[0]),
      .req_out_spinor_1    (req_v.fo[1]),
      .req_out_spinor_2    (req_v.fo[2]),
      .req_out_spinor_3    (req_v.fo[3]),
      .req_in_spinor_0     (req_v.fi[0]),
      .req_in_spinor_1     (req_v.fi[1]),
      .req_in_spinor_2     (req_v.fi[2]),
      .req_in_spinor_3     (req_v.fi[3]),
      .req_polarization_0  (req_v.eps[0]),
      .req_polarization_1  (req_v.eps[1]),
      .req_polarization_2  (req_v.eps[2]),
      .req_polarization_3  (req_v.eps[3]),
      .rsp_valid           (rsp_valid),
      .rsp_amplitude_value (rsp_amplitude_value),
      .rsp_saturated       (rsp_saturated),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result monitor. Outputs are read right at the edge, before the DUT's
   // nonblocking updates land, so this sees the cycle that the edge ends.
   always @(posedge clock) begin
      if (!reset) begin
         if ($isunknown(rsp_valid)) begin
            $display("%0t: rsp_valid mismatch, expected 0 or 1 actual %b", $time, rsp_valid);
            amp_board.mismatches++;
         end else if (rsp_valid) begin
            amp_board.check_amplitude(rsp_amplitude_value, rsp_saturated);
         end
      end
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[ffv_vertex_amplitude_top] ERROR");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic logic [PART_W-1:0] rand_part(val_style_type s);
      logic [PART_W-1:0] r;
      case (s)
         VAL_UNIT: r = $urandom_range(32'h0200_0000) - 32'h0100_0000;  // about +-1.0
         VAL_WIDE: r = $urandom_range(32'h1000_0000) - 32'h0800_0000;  // about +-8.0
         VAL_FULL: r = $urandom;
         default: begin
            case ($urandom_range(5))
               0:       r = 32'h0000_0000;
               1:       r = 32'h7FFF_FFFF;
               2:       r = 32'h8000_0000;
               3:       r = 32'hFFFF_FFFF;
               4:       r = 32'h0000_0001;
               default: r = 32'h0080_0000;
            endcase
         end
      endcase
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] rand_word(val_style_type s);
      return {rand_part(s), rand_part(s)};
   endfunction

   function automatic val_style_type pick_style();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 60)
         return VAL_UNIT;
      else if (pick < 75)
         return VAL_WIDE;
      else if (pick < 90)
         return VAL_FULL;
      else
         return VAL_EDGE;
   endfunction

   // Mostly unit-range values so the sum stays in range and the rounding is
   // exercised; the rest saturates. Edge-style vertices mix styles per lane.
   function automatic vertex_type rand_vertex();
      vertex_type    v;
      val_style_type s;
      bit            mixed, sparse;
      int            k;
      s      = pick_style();
      mixed  = (s == VAL_EDGE);
      sparse = ($urandom_range(7) == 0);
      for (k = 0; k < N_LANE; k++) begin
         if (mixed)
            s = val_style_type'($urandom_range(3));
         v.fo[k]  = rand_word(s);
         v.fi[k]  = rand_word(s);
         v.eps[k] = rand_word(s);
         // sparse vertices knock out lanes so single terms show
         if (sparse && $urandom_range(1)) v.fo[k] = '0;
         if (sparse && $urandom_range(1)) v.fi[k] = '0;
         if (sparse && $urandom_range(1)) v.eps[k] = '0;
      end
      return v;
   endfunction

   function automatic vertex_type flat_vertex(logic [WORD_W-1:0] w);
      vertex_type v;
      v.fo  = {N_LANE{w}};
      v.fi  = {N_LANE{w}};
      v.eps = {N_LANE{w}};
      return v;
   endfunction

   function automatic vertex_type spot_vertex(int o, int f, int e,
                                              logic [WORD_W-1:0] fw, logic [WORD_W-1:0] ew);
      vertex_type v;
      v        = '0;
      v.fo[o]  = fw;
      v.fi[f]  = W_ONE;
      v.eps[e] = ew;
      return v;
   endfunction

   // most transactions back to back, some short gaps, a few long ones
   function automatic int unsigned pick_gap(bit steady);
      int unsigned pick;
      pick = $urandom_range(99);
      if (steady || pick < 65)
         return 0;
      else if (pick < 93)
         return $urandom_range(3, 1);
      else
         return $urandom_range(40, 8);
   endfunction

   // Drive one request transaction and wait for the edge that accepts it.
   // start stays high afterwards; the caller lowers it when a gap follows.
   task automatic send_vertex(vertex_type v);
      start <= 1'b1;
      req_v <= v;
      do @(posedge clock); while (busy !== 1'b0);
      amp_board.note_vertex(v);
   endtask

   // idle the request side for n > 0 cycles with junk on the payload
   task automatic hold_off(int unsigned n);
      start <= 1'b0;
      req_v <= rand_vertex();
      repeat (n) @(posedge clock);
   endtask

   // stop sending and wait until every expected amplitude has come back
   task automatic drain_pipe();
      start <= 1'b0;
      while (amp_board.amplitudes_due.size() != 0) @(posedge clock);
   endtask

   // register write; csr_valid stays high until csr_release
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      amp_board.write_coupling(idx, data);
   endtask

   task automatic csr_release();
      csr_valid <= 1'b0;
      csr_index <= CSR_IDX_W'($urandom);
      csr_data  <= {$urandom, $urandom};
   endtask

   // One phase: drain, load both couplings (sometimes a stray write to an
   // unmapped index too), then a stream of random transactions with one
   // full drain in the middle.
   task automatic run_phase(logic [WORD_W-1:0] left, logic [WORD_W-1:0] right,
                            int unsigned n_items);
      int unsigned gap;
      bit          steady;
      int unsigned i;
      drain_pipe();
      if ($urandom_range(1)) begin
         write_csr(CSR_COUPLING_LEFT, left);
         write_csr(CSR_COUPLING_RIGHT, right);
      end else begin
         write_csr(CSR_COUPLING_RIGHT, right);
         write_csr(CSR_COUPLING_LEFT, left);
      end
      if ($urandom_range(2) == 0)
         write_csr($urandom_range(1) ? CSR_SPARE_A : CSR_SPARE_B, {$urandom, $urandom});
      csr_release();
      steady = 1'b0;
      for (i = 0; i < n_items; i++) begin
         if (i % 16 == 0)
            steady = ($urandom_range(3) == 0);  // stretch with no idling
         send_vertex(rand_vertex());
         if (i == n_items / 2) begin
            drain_pipe();
         end else begin
            gap = pick_gap(steady);
            if (gap != 0)
               hold_off(gap);
         end
      end
   endtask

   function automatic logic [WORD_W-1:0] rand_coupling();
      return rand_word(pick_style());
   endfunction

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int          k, f, o, e;
      vertex_type  v;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // couplings still at their reset value: amplitudes must come back zero
      send_vertex(flat_vertex(W_MAX));
      send_vertex(rand_vertex());
      drain_pipe();

      write_csr(CSR_COUPLING_LEFT, W_ONE);
      write_csr(CSR_COUPLING_RIGHT, W_ONE);
      csr_release();

      // field extremes
      send_vertex(flat_vertex(W_ZERO));
      send_vertex(flat_vertex(W_MAX));
      send_vertex(flat_vertex(W_MIN));
      send_vertex(flat_vertex(W_MONE));

      // each (incoming lane, outgoing lane) pair that feeds a term, with a
      // polarization component that reaches it; odd ones use an imaginary unit
      for (k = 0; k < 8; k++) begin
         f = k % 4;
         o = ((f < 2) ? 2 : 0) + ((k / 4) ^ (f % 2));
         if (((o % 2) ^ (f % 2)) == 0)
            e = (k < 4) ? 0 : 3;
         else
            e = (k < 4) ? 1 : 2;
         send_vertex(spot_vertex(o, f, e, W_ONE, (k % 2) ? W_I : W_ONE));
      end

      // round half up on an exact half ulp: +1 ulp * 0.5 -> 1, -1 ulp * 0.5 -> 0
      send_vertex(spot_vertex(2, 0, 0, W_LSB, W_HALF));
      send_vertex(spot_vertex(2, 0, 0, W_NLSB, W_HALF));

      // clipping of the real part alone, upward and downward
      v = spot_vertex(2, 0, 0, W_TWO, W_RMAX);
      send_vertex(v);
      v = spot_vertex(2, 0, 0, W_TWO, W_RMIN);
      send_vertex(v);

      // random phases; the first two pin the coupling extremes, the next two zero one coupling
      for (k = 0; k < N_PHASES; k++) begin
         case (k)
            0:       run_phase(W_MAX, W_MIN, PHASE_ITEMS);
            1:       run_phase(W_MIN, W_MAX, PHASE_ITEMS);
            2:       run_phase(W_ZERO, rand_coupling(), PHASE_ITEMS);
            3:       run_phase(rand_coupling(), W_ZERO, PHASE_ITEMS);
            default: run_phase(rand_coupling(), rand_coupling(), PHASE_ITEMS);
         endcase
      end

      // all transactions in; wait for the tail and catch any stray result
      drain_pipe();
      repeat (FLUSH_CYCLES) @(posedge clock);
      if (amp_board.mismatches == 0 && amp_board.amplitudes_due.size() == 0)
         $display("[ffv_vertex_amplitude_top] OK");
      else
         $display("[ffv_vertex_amplitude_top] ERROR");
      $finish;
   end

endmodule
